[rtl/lba_pkg.sv]
`default_nettype none

package lba_pkg;

    localparam int LEVEL_W    = 16;
    localparam int ACC_W      = 4;
    localparam int DT_W       = 16;
    localparam int CH_W       = 8;
    localparam int IDX_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W     = CH_W + LEVEL_W;

    // 255.0 in 8.8
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'hFF00;
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 16'h0000;
    localparam int                 PERIOD_MS  = 10;

    typedef enum logic [1:0] {
        MODE_STATIC   = 2'd0,
        MODE_FADE_IN  = 2'd1,
        MODE_FADE_OUT = 2'd2,
        MODE_SWING    = 2'd3
    } anim_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANIM_MODE     = 3'd0,
        REG_REPEAT_ENABLE = 3'd1,
        REG_BASE_COLOR    = 3'd2,
        REG_LEVEL_STEP    = 3'd3,
        REG_SPAN_START    = 3'd4,
        REG_SPAN_LENGTH   = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        ACT_TIME  = 1'b0,
        ACT_START = 1'b1
    } action_t;

    typedef struct packed {
        anim_mode_t         anim_mode;
        logic               repeat_enable;
        logic [23:0]        base_color;
        logic [LEVEL_W-1:0] level_step;
        logic [IDX_W-1:0]   span_start;
        logic [IDX_W-1:0]   span_length;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               done;
    } emit_t;

    // floor(y / 255) for any 16-bit y, then clamp to 8 bits
    function automatic logic [CH_W-1:0] div255_sat(input logic [LEVEL_W-1:0] y);
        logic [LEVEL_W:0]  s;
        logic [CH_W:0]     q;
        s = {1'b0, y} + 17'd1 + {9'd0, y[LEVEL_W-1:CH_W]};
        q = s[LEVEL_W:CH_W];
        return q[CH_W] ? {CH_W{1'b1}} : q[CH_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/lba_cfg.sv]
`default_nettype none

module lba_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lba_pkg::CFG_DATA_W-1:0] cfg_data,
    output lba_pkg::cfg_t                       cfg
);
    import lba_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ANIM_MODE:     cfg_next.anim_mode     = anim_mode_t'(cfg_data[1:0]);
                REG_REPEAT_ENABLE: cfg_next.repeat_enable = cfg_data[0];
                REG_BASE_COLOR:    cfg_next.base_color    = cfg_data[23:0];
                REG_LEVEL_STEP:    cfg_next.level_step    = cfg_data[LEVEL_W-1:0];
                REG_SPAN_START:    cfg_next.span_start    = cfg_data[IDX_W-1:0];
                REG_SPAN_LENGTH:   cfg_next.span_length   = cfg_data[IDX_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.anim_mode     <= MODE_STATIC;
            cfg_reg.repeat_enable <= 1'b0;
            cfg_reg.base_color    <= '0;
            cfg_reg.level_step    <= 16'd256;
            cfg_reg.span_start    <= '0;
            cfg_reg.span_length   <= 8'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lba_ctrl.sv]
`default_nettype none

module lba_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lba_pkg::cfg_t            cfg,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     in_action,
    input  wire logic [lba_pkg::DT_W-1:0] in_dt,
    output logic                          e_valid,
    input  wire logic                     e_ready,
    output lba_pkg::emit_t                e
);
    import lba_pkg::*;

    logic               item_valid_reg, item_valid_next;
    action_t            item_action_reg;
    logic [DT_W-1:0]    item_dt_reg;

    logic               running_reg, running_next;
    logic               finished_reg, finished_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               rising_reg, rising_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;

    logic               e_valid_reg, e_valid_next;
    emit_t              e_reg, e_next;

    logic               e_adv;
    logic               emit_now;
    logic [DT_W:0]      acc_sum;
    logic [LEVEL_W:0]   up_sum;
    logic               up_end;
    logic               down_end;
    logic [LEVEL_W-1:0] load_level;

    assign e_adv    = !e_valid_reg || e_ready;
    assign in_ready = !item_valid_reg || e_adv;
    assign e_valid  = e_valid_reg;
    assign e        = e_reg;

    assign acc_sum  = {{(DT_W + 1 - ACC_W){1'b0}}, acc_reg} + {1'b0, item_dt_reg};
    assign up_sum   = {1'b0, level_reg} + {1'b0, cfg.level_step};
    assign up_end   = up_sum >= {1'b0, LEVEL_FULL};
    assign down_end = cfg.level_step >= level_reg;
    assign load_level = (cfg.anim_mode == MODE_FADE_IN || cfg.anim_mode == MODE_SWING)
                        ? LEVEL_ZERO : LEVEL_FULL;

    always_comb
    begin
        running_next  = running_reg;
        finished_next = finished_reg;
        level_next    = level_reg;
        rising_next   = rising_reg;
        acc_next      = acc_reg;
        emit_now      = 1'b0;

        if (item_valid_reg && e_adv)
        begin
            if (item_action_reg == ACT_START)
            begin
                running_next  = 1'b1;
                finished_next = 1'b0;
                level_next    = load_level;
            end
            else if (running_reg && !finished_reg)
            begin
                if (cfg.anim_mode == MODE_STATIC)
                begin
                    emit_now = 1'b1;
                end
                else if (acc_sum < (DT_W + 1)'(PERIOD_MS))
                begin
                    acc_next = acc_sum[ACC_W-1:0];
                end
                else
                begin
                    acc_next = '0;
                    emit_now = 1'b1;
                    case (cfg.anim_mode) inside
                        MODE_FADE_IN, MODE_FADE_OUT:
                        begin
                            if ((cfg.anim_mode == MODE_FADE_IN) ? up_end : down_end)
                            begin
                                // ramp end: restart or finish
                                if (cfg.repeat_enable)
                                begin
                                    running_next  = 1'b1;
                                    finished_next = 1'b0;
                                    level_next    = load_level;
                                end
                                else
                                begin
                                    finished_next = 1'b1;
                                end
                            end
                            else if (cfg.anim_mode == MODE_FADE_IN)
                            begin
                                level_next = up_sum[LEVEL_W-1:0];
                            end
                            else
                            begin
                                level_next = level_reg - cfg.level_step;
                            end
                        end
                        MODE_SWING:
                        begin
                            // direction flips at either end without moving
                            if (rising_reg)
                            begin
                                if (up_end)
                                    rising_next = 1'b0;
                                else
                                    level_next = up_sum[LEVEL_W-1:0];
                            end
                            else
                            begin
                                if (down_end)
                                    rising_next = 1'b1;
                                else
                                    level_next = level_reg - cfg.level_step;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end

        e_next.level    = level_next;
        e_next.done     = finished_next;
        e_valid_next    = e_adv ? (item_valid_reg && emit_now) : e_valid_reg;
        item_valid_next = in_ready ? in_valid : item_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            e_valid_reg    <= 1'b0;
            running_reg    <= 1'b0;
            finished_reg   <= 1'b0;
            level_reg      <= '0;
            rising_reg     <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            e_valid_reg    <= e_valid_next;
            running_reg    <= running_next;
            finished_reg   <= finished_next;
            level_reg      <= level_next;
            rising_reg     <= rising_next;
            acc_reg        <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_action_reg <= action_t'(in_action);
            item_dt_reg     <= in_dt;
        end
        if (e_adv)
        begin
            e_reg <= e_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lba_scale.sv]
`default_nettype none

module lba_scale (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lba_pkg::cfg_t              cfg,
    input  wire logic                       e_valid,
    output logic                            e_ready,
    input  wire lba_pkg::emit_t             e,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [lba_pkg::CH_W-1:0]        out_red,
    output logic [lba_pkg::CH_W-1:0]        out_green,
    output logic [lba_pkg::CH_W-1:0]        out_blue,
    output logic [lba_pkg::IDX_W-1:0]       out_first,
    output logic [lba_pkg::IDX_W-1:0]       out_count,
    output logic                            out_done
);
    import lba_pkg::*;

    logic               p_valid_reg, p_valid_next;
    logic [LEVEL_W-1:0] p_red_reg, p_green_reg, p_blue_reg;
    logic               p_done_reg;

    logic               o_valid_reg, o_valid_next;
    logic [CH_W-1:0]    o_red_reg, o_green_reg, o_blue_reg;
    logic [IDX_W-1:0]   o_first_reg, o_count_reg;
    logic               o_done_reg;

    logic               o_adv;
    logic [PROD_W-1:0]  prod_red, prod_green, prod_blue;

    assign o_adv   = !o_valid_reg || out_ready;
    assign e_ready = !p_valid_reg || o_adv;

    // channel * level, low byte dropped: the /256 part of /(255*256)
    assign prod_red   = PROD_W'(cfg.base_color[23:16]) * PROD_W'(e.level);
    assign prod_green = PROD_W'(cfg.base_color[15:8])  * PROD_W'(e.level);
    assign prod_blue  = PROD_W'(cfg.base_color[7:0])   * PROD_W'(e.level);

    assign p_valid_next = e_ready ? e_valid : p_valid_reg;
    assign o_valid_next = o_adv ? p_valid_reg : o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready)
        begin
            p_red_reg   <= prod_red[PROD_W-1:CH_W];
            p_green_reg <= prod_green[PROD_W-1:CH_W];
            p_blue_reg  <= prod_blue[PROD_W-1:CH_W];
            p_done_reg  <= e.done;
        end
        if (o_adv)
        begin
            o_red_reg   <= div255_sat(p_red_reg);
            o_green_reg <= div255_sat(p_green_reg);
            o_blue_reg  <= div255_sat(p_blue_reg);
            o_first_reg <= cfg.span_start;
            o_count_reg <= cfg.span_length;
            o_done_reg  <= p_done_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_red   = o_red_reg;
    assign out_green = o_green_reg;
    assign out_blue  = o_blue_reg;
    assign out_first = o_first_reg;
    assign out_count = o_count_reg;
    assign out_done  = o_done_reg;

endmodule

`default_nettype wire

[rtl/led_brightness_animator.sv]
// led brightness animator
// input stream: s_tuser = action (0 time advance, 1 start), s_tdata[15:0] = elapsed ms.
// a start transfer arms the animation and loads the level; it gives no result.
// time transfers give one result when the animation updates, only while it runs and is
// not finished: every time transfer in static mode, otherwise once 10 ms or more have built up.
// output stream: m_tdata carries the scaled red, green, blue, the first led index
// and the led count; m_tuser is the done flag of a finished non-repeating ramp.
// a result reaches m_tvalid through the input register, the level update into the
// emit register, the channel multiply, and the divide by 255 into the output
// register. throughput: one item per cycle while the output is not stalled, as the
// level update feeds the next item's state directly.
// a stalled receiver holds the output register; the stages behind it keep filling,
// and s_tready drops only once all of them are occupied.
// config writes go through cfg_valid/cfg_index/cfg_data, always ready; write only
// while no item is in flight.
// reset: registers take their defaults (static mode, step 1.0, span 0/1), the
// animation is idle, and all pipeline stages are empty.
`default_nettype none

module led_brightness_animator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // elapsed_ms
    input  wire logic        s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // fill_red, fill_green, fill_blue, fill_first, fill_count
    output logic             m_tuser,   // done_flag
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import lba_pkg::*;

    cfg_t            cfg;
    logic            e_valid;
    logic            e_ready;
    emit_t           e;
    logic [CH_W-1:0]  fill_red, fill_green, fill_blue;
    logic [IDX_W-1:0] fill_first, fill_count;

    lba_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_dt     (s_tdata),
        .e_valid   (e_valid),
        .e_ready   (e_ready),
        .e         (e)
    );

    lba_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .e_valid   (e_valid),
        .e_ready   (e_ready),
        .e         (e),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_red   (fill_red),
        .out_green (fill_green),
        .out_blue  (fill_blue),
        .out_first (fill_first),
        .out_count (fill_count),
        .out_done  (m_tuser)
    );

    assign m_tdata = {fill_count, fill_first, fill_blue, fill_green, fill_red};

    // input side backs up only when every stage is full and the output is stalled
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low without a stalled output");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid |-> (e.level <= LEVEL_FULL))
        else $error("level above full scale");

    a_red_not_above_base: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (fill_red <= cfg.base_color[23:16]))
        else $error("scaled red exceeds base red");

endmodule

`default_nettype wire
